// ===== design/hc2_pkg.sv =====
// Shared types, constants and helper functions for the 2x2 Hill cipher core.
// Used by the controller, the datapath and the port checker.
// No dependencies.
package hc2_pkg;

    localparam int unsigned SYM_W  = 5;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 5;

    localparam logic [SYM_W-1:0] MOD_SYM   = 5'd28;
    localparam logic [SYM_W-1:0] SYM_SPACE = 5'd26;
    localparam logic [SYM_W-1:0] SYM_DOT   = 5'd27;

    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;

    // Register indexes on the configuration port.
    localparam logic [CFG_AW-1:0] CFG_KEY_A   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_KEY_B   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_KEY_C   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_KEY_D   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DECRYPT = 3'd4;

    localparam logic [SYM_W-1:0] RST_KEY_A = 5'd25;
    localparam logic [SYM_W-1:0] RST_KEY_B = 5'd25;
    localparam logic [SYM_W-1:0] RST_KEY_C = 5'd5;
    localparam logic [SYM_W-1:0] RST_KEY_D = 5'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_CHAR = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_KEY  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hold_first;
        logic capture_pair;
        logic do_key;
        logic do_det;
        logic do_inv;
        logic do_mat;
        logic do_red;
        logic do_mul;
        logic do_sum;
        logic out_second;
    } hc2_cmd_t;

    // Maps an ASCII character to {known, symbol}; unknown characters give symbol 0.
    function automatic logic [SYM_W:0] sym_of(input logic [CHAR_W-1:0] ch);
        logic [SYM_W:0] res;
        res = '0;
        if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
            res = {1'b1, SYM_W'(ch - CHAR_LOW_A)};
        end else if (ch == CHAR_SPACE) begin
            res = {1'b1, SYM_SPACE};
        end else if (ch == CHAR_DOT) begin
            res = {1'b1, SYM_DOT};
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] char_of(input logic [SYM_W-1:0] s);
        logic [CHAR_W-1:0] res;
        if (s < SYM_SPACE) begin
            res = CHAR_LOW_A + CHAR_W'(s);
        end else if (s == SYM_SPACE) begin
            res = CHAR_SPACE;
        end else begin
            res = CHAR_DOT;
        end
        return res;
    endfunction

    // Brings a key register value (0..31) into the range 0..27.
    function automatic logic [SYM_W-1:0] red_key(input logic [SYM_W-1:0] v);
        return (v >= MOD_SYM) ? SYM_W'(v - MOD_SYM) : v;
    endfunction

    // Residue mod 28 of an 11-bit value. The quotient estimate v*146/4096 is at
    // most one below the true quotient, so a single correction step suffices.
    function automatic logic [SYM_W-1:0] mod28(input logic [10:0] v);
        logic [18:0] prod;
        logic [6:0]  q;
        logic [11:0] r;
        prod = {8'b0, v} * 19'd146;
        q    = prod[18:12];
        r    = {1'b0, v} - 12'(q) * 12'd28;
        return (r >= 12'd28) ? SYM_W'(r - 12'd28) : SYM_W'(r);
    endfunction

    // Additive inverse mod 28 of a residue.
    function automatic logic [SYM_W-1:0] neg28(input logic [SYM_W-1:0] v);
        return (v == '0) ? '0 : SYM_W'(MOD_SYM - v);
    endfunction

    // Multiplicative inverse mod 28; zero where none exists.
    function automatic logic [SYM_W-1:0] inv28(input logic [SYM_W-1:0] v);
        logic [SYM_W-1:0] res;
        case (v)
            5'd1:    res = 5'd1;
            5'd3:    res = 5'd19;
            5'd5:    res = 5'd17;
            5'd9:    res = 5'd25;
            5'd11:   res = 5'd23;
            5'd13:   res = 5'd13;
            5'd15:   res = 5'd15;
            5'd17:   res = 5'd5;
            5'd19:   res = 5'd3;
            5'd23:   res = 5'd11;
            5'd25:   res = 5'd9;
            5'd27:   res = 5'd27;
            default: res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/hc2_ctrl.sv =====
// Controller of the Hill cipher core: pairs up input items, steps the datapath
// through its stages and hands out the two result items.
// Depends on hc2_pkg.
module hc2_ctrl
    import hc2_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output hc2_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_KEY  = 10'b00_0000_0010,
        S_DET  = 10'b00_0000_0100,
        S_INV  = 10'b00_0000_1000,
        S_MAT  = 10'b00_0001_0000,
        S_RED  = 10'b00_0010_0000,
        S_MUL  = 10'b00_0100_0000,
        S_SUM  = 10'b00_1000_0000,
        S_OUT0 = 10'b01_0000_0000,
        S_OUT1 = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   have_first_reg, have_first_next;
    logic   in_fire;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        have_first_next = have_first_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (have_first_reg) begin
                        cmd.capture_pair = 1'b1;
                        have_first_next  = 1'b0;
                        state_next       = S_KEY;
                    end else begin
                        cmd.hold_first  = 1'b1;
                        have_first_next = 1'b1;
                    end
                end
            end
            S_KEY: begin
                cmd.do_key = 1'b1;
                state_next = S_DET;
            end
            S_DET: begin
                cmd.do_det = 1'b1;
                state_next = S_INV;
            end
            S_INV: begin
                cmd.do_inv = 1'b1;
                state_next = S_MAT;
            end
            S_MAT: begin
                cmd.do_mat = 1'b1;
                state_next = S_RED;
            end
            S_RED: begin
                cmd.do_red = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.do_mul = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.do_sum = 1'b1;
                state_next = S_OUT0;
            end
            S_OUT0: begin
                if (m_tready) begin
                    state_next = S_OUT1;
                end
            end
            S_OUT1: begin
                cmd.out_second = 1'b1;
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            have_first_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            have_first_reg <= have_first_next;
        end
    end

endmodule

// ===== design/hc2_dpath.sv =====
// Datapath of the Hill cipher core: key registers, held symbols and the staged
// determinant, inverse and matrix arithmetic mod 28.
// Depends on hc2_pkg; driven by hc2_ctrl through hc2_cmd_t.
module hc2_dpath
    import hc2_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  hc2_cmd_t          cmd,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output logic [CHAR_W-1:0] out_char,
    output logic [STAT_W-1:0] status,
    output logic              last
);

    logic [SYM_W-1:0]  key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic              decrypt_reg;

    logic [SYM_W:0]    in_sym;
    logic [SYM_W-1:0]  held_sym_reg, y_sym_reg;
    logic              held_ok_reg, y_ok_reg;

    logic [SYM_W-1:0]  ka_reg, kb_reg, kc_reg, kd_reg;
    logic [9:0]        prod_ad_reg, prod_bc_reg;
    logic [SYM_W-1:0]  det_reg, inv_reg;
    logic [SYM_W-1:0]  factor;
    logic [9:0]        pm_reg [4];
    logic [SYM_W-1:0]  m_reg [4];
    logic [9:0]        t_reg [4];
    logic [SYM_W-1:0]  s0, s1;
    logic [STAT_W-1:0] stat_calc;
    logic [CHAR_W-1:0] res0_reg, res1_reg;
    logic [STAT_W-1:0] status_reg;

    assign in_sym = sym_of(in_char);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_a_reg   <= RST_KEY_A;
            key_b_reg   <= RST_KEY_B;
            key_c_reg   <= RST_KEY_C;
            key_d_reg   <= RST_KEY_D;
            decrypt_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_KEY_A:   key_a_reg   <= cfg_wdata;
                CFG_KEY_B:   key_b_reg   <= cfg_wdata;
                CFG_KEY_C:   key_c_reg   <= cfg_wdata;
                CFG_KEY_D:   key_d_reg   <= cfg_wdata;
                CFG_DECRYPT: decrypt_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // The decrypt matrix is inv(det) times the adjugate; encrypt uses the key.
    assign factor = decrypt_reg ? inv_reg : 5'd1;

    always_comb begin
        s0 = mod28({1'b0, t_reg[0]} + {1'b0, t_reg[1]});
        s1 = mod28({1'b0, t_reg[2]} + {1'b0, t_reg[3]});
        if (inv_reg == '0) begin
            stat_calc = STAT_BAD_KEY;
        end else if (!(held_ok_reg && y_ok_reg)) begin
            stat_calc = STAT_BAD_CHAR;
        end else begin
            stat_calc = STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hold_first) begin
            held_sym_reg <= in_sym[SYM_W-1:0];
            held_ok_reg  <= in_sym[SYM_W];
        end
        if (cmd.capture_pair) begin
            y_sym_reg <= in_sym[SYM_W-1:0];
            y_ok_reg  <= in_sym[SYM_W];
        end
        if (cmd.do_key) begin
            ka_reg      <= red_key(key_a_reg);
            kb_reg      <= red_key(key_b_reg);
            kc_reg      <= red_key(key_c_reg);
            kd_reg      <= red_key(key_d_reg);
            prod_ad_reg <= 10'(red_key(key_a_reg)) * 10'(red_key(key_d_reg));
            prod_bc_reg <= 10'(red_key(key_b_reg)) * 10'(red_key(key_c_reg));
        end
        if (cmd.do_det) begin
            // Adding 28*28 keeps the difference positive before reduction.
            det_reg <= mod28({1'b0, prod_ad_reg} + 11'd784 - {1'b0, prod_bc_reg});
        end
        if (cmd.do_inv) begin
            inv_reg <= inv28(det_reg);
        end
        if (cmd.do_mat) begin
            pm_reg[0] <= 10'(factor) * 10'(decrypt_reg ? kd_reg : ka_reg);
            pm_reg[1] <= 10'(factor) * 10'(decrypt_reg ? neg28(kb_reg) : kb_reg);
            pm_reg[2] <= 10'(factor) * 10'(decrypt_reg ? neg28(kc_reg) : kc_reg);
            pm_reg[3] <= 10'(factor) * 10'(decrypt_reg ? ka_reg : kd_reg);
        end
        if (cmd.do_red) begin
            for (int i = 0; i < 4; i++) begin
                m_reg[i] <= mod28({1'b0, pm_reg[i]});
            end
        end
        if (cmd.do_mul) begin
            t_reg[0] <= 10'(m_reg[0]) * 10'(held_sym_reg);
            t_reg[1] <= 10'(m_reg[1]) * 10'(y_sym_reg);
            t_reg[2] <= 10'(m_reg[2]) * 10'(held_sym_reg);
            t_reg[3] <= 10'(m_reg[3]) * 10'(y_sym_reg);
        end
        if (cmd.do_sum) begin
            status_reg <= stat_calc;
            res0_reg   <= (stat_calc == STAT_OK) ? char_of(s0) : '0;
            res1_reg   <= (stat_calc == STAT_OK) ? char_of(s1) : '0;
        end
    end

    assign out_char = cmd.out_second ? res1_reg : res0_reg;
    assign status   = status_reg;
    assign last     = cmd.out_second;

endmodule

// ===== design/hill_cipher_2x2_mod28_core.sv =====
// 2x2 Hill cipher over a 28-symbol alphabet (a-z, space, period). Characters
// arrive one item at a time; the first of each pair is held, the second starts
// the arithmetic and the pair's two result items follow, the second with tlast
// set. After the second character's acceptance the controller steps through
// seven stages of the shared mod-28 datapath (key reduction and products,
// determinant, inverse, matrix, reduction, vector products, sums), then offers
// the two results in turn, each held until m_tready takes it. The input is not
// ready meanwhile, so no new character is taken until the pair's second result
// has been accepted.
// Status 2 flags a key whose determinant is not invertible mod 28, status 1 an
// unknown character; both give zero characters. Keys and mode are set through
// the write port.
module hill_cipher_2x2_mod28_core
    import hc2_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] in_char
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] out_char
    output logic [STAT_W-1:0] m_tuser,   // [1:0] status
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    hc2_cmd_t cmd;

    hc2_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    hc2_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_char   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .out_char  (m_tdata),
        .status    (m_tuser),
        .last      (m_tlast)
    );

endmodule

// ===== design/hc2_checker.sv =====
// Port-level checks for the Hill cipher core, attached by bind.
// Depends on hc2_pkg and on hill_cipher_2x2_mod28_core's ports.
module hc2_checker
    import hc2_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [CHAR_W-1:0] s_tdata,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CHAR_W-1:0] m_tdata,
    input logic [STAT_W-1:0] m_tuser,
    input logic              m_tlast,
    input logic              cfg_we,
    input logic [CFG_AW-1:0] cfg_addr,
    input logic [CFG_DW-1:0] cfg_wdata
);

    // A stalled result item keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result item changed while stalled");

    // An error status always carries a zero character.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
        else $error("error result with non-zero character");

    // The first result of a pair is followed at once by the second.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second result of pair missing");

    // Both results of a pair report the same status.
    a_same_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tuser == $past(m_tuser))
        else $error("status differs within a pair");

    // The input is not taken while a result is on offer.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while results pending");

endmodule

bind hill_cipher_2x2_mod28_core hc2_checker u_hc2_checker (.*);
